// ===== rtl/arp_pkg.sv =====
// Package: shared types, constants and table builder for the attenuated ray projector
`default_nettype none
package arp_pkg;

    localparam int EXP_DEPTH_DEFAULT = 256;
    localparam logic [15:0] HALF_STEP_RESET = 16'd32768;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_STEP = 2'd0;
    localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] MU_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MU1,
        ST_EXP,
        ST_ACC,
        ST_OUT
    } state_t;

    // Per-lane products
    typedef struct packed {
        logic [31:0] aw;
        logic [31:0] iw;
    } lane_prod_t;

    // Build exp(-16k/depth) entry k in Q1.15 by the integer recurrence
    function automatic logic [15:0] exp_entry(input int depth, input int k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] cur;
        x = (64'd1 << 34) / 64'(depth);
        term = 64'd1 << 30;
        r = term;
        cur = 64'd1 << 30;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x) >> 30) / 64'(n);
            if (n % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        for (int j = 0; j < k; j++) begin
            cur = (cur * r + (64'd1 << 29)) >> 30;
        end
        return 16'((cur + (64'd1 << 14)) >> 15);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/arp_if.sv =====
// Interfaces: input sample channel and result channel
`default_nettype none
interface arp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] img_value_a;
    logic [15:0] atten_value_a;
    logic [15:0] weight_a;
    logic        valid_a;
    logic [15:0] img_value_b;
    logic [15:0] atten_value_b;
    logic [15:0] weight_b;
    logic        valid_b;
    logic        last_sample;
    modport source (output valid, img_value_a, atten_value_a, weight_a, valid_a,
                    img_value_b, atten_value_b, weight_b, valid_b, last_sample,
                    input ready);
    modport sink (input valid, img_value_a, atten_value_a, weight_a, valid_a,
                  img_value_b, atten_value_b, weight_b, valid_b, last_sample,
                  output ready);
endinterface

interface arp_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] line_integral;
    logic        saturated;
    modport source (output valid, line_integral, saturated, input ready);
    modport sink (input valid, line_integral, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/arp_lane.sv =====
// One interpolation point lane: gated attenuation and image products
`default_nettype none
module arp_lane (
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic [15:0] img,
    input  wire logic [15:0] att,
    input  wire logic [15:0] weight,
    input  wire logic        pvalid,
    output arp_pkg::lane_prod_t prod
);
    arp_pkg::lane_prod_t prod_reg;

    // Register both products, zero when the point is outside the image
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg.aw <= pvalid ? att * weight : 32'd0;
            prod_reg.iw <= pvalid ? img * weight : 32'd0;
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

// ===== rtl/arp_exp.sv =====
// Exp(-mu) lookup with linear interpolation, registered result
`default_nettype none
module arp_exp #(
    parameter int EXP_TABLE_DEPTH = arp_pkg::EXP_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic [31:0] mu,
    output logic      [15:0] e
);
    localparam int LD = $clog2(EXP_TABLE_DEPTH);
    localparam int PW = 32 + LD - 4;

    logic [15:0] tbl [EXP_TABLE_DEPTH];
    logic [PW-1:0] pos;
    logic [PW-17:0] idx;
    logic [15:0] f;
    logic [15:0] t0, t1, d;
    logic [31:0] prod;
    logic [15:0] e_next;
    logic [15:0] e_reg;

    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++)
    begin : g_tbl
        assign tbl[k] = arp_pkg::exp_entry(EXP_TABLE_DEPTH, k);
    end

    assign pos = PW'({mu, LD'(0)} >> 4);
    assign idx = pos[PW-1:16];
    assign f   = pos[15:0];

    // Interpolate between neighbors, zero past the end
    always_comb
    begin
        t0 = 16'd0;
        t1 = 16'd0;
        if (idx < (PW-16)'(EXP_TABLE_DEPTH))
        begin
            t0 = tbl[idx[LD-1:0]];
            if (idx + 1'b1 < (PW-16)'(EXP_TABLE_DEPTH))
                t1 = tbl[LD'(idx + 1'b1)];
        end
        if (t1 > t0)
            t1 = t0;
        d = t0 - t1;
        prod = d * f + 32'd32768;
        e_next = t0 - prod[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            e_reg <= e_next;
    end

    assign e = e_reg;
endmodule
`default_nettype wire

// ===== rtl/attenuated_ray_projector_unit.sv =====
// Top level: attenuated forward projector with two point lanes and merge stage
//
// Usage: samples of one ray arrive in order on the in channel (valid/ready);
// each transfer carries two interpolation points. The two lanes form the
// weighted attenuation and image products, a merge stage adds them, scales
// by half_step, updates mu, looks up exp(-mu) and accumulates the ray sum.
// A sample steps through the states idle (transfer into the lanes), mu1 (scale
// and first mu update), exp (exp lookup) and acc (accumulate and second mu
// update), set by the chain of dependent multiplies and the table path.
// Ready is high only between samples. The sample marked last produces one
// result on the out channel: the saturated Q24.16 sum and a clip flag; the
// accumulators clear. After acc it passes through an extra output state,
// from which the result is written into the output register.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new sample once the next ray ends.
// Reset clears mu, the sum, the clip flag and restores half_step to 0.5.
// half_step is written through the APB port at address 0.
`default_nettype none
module attenuated_ray_projector_unit #(
    parameter int EXP_TABLE_DEPTH = arp_pkg::EXP_DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    arp_in_if.sink    in_ch,
    arp_out_if.source out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [arp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    arp_pkg::state_t state_reg, state_next;
    arp_pkg::lane_prod_t prod_a, prod_b;
    logic [15:0] half_step_reg;
    logic [31:0] mu_reg, mu_next;
    logic [39:0] sum_reg, sum_next;
    logic        clip_reg, clip_next;
    logic        last_reg;
    logic [20:0] self_reg;
    logic [20:0] self_add;
    logic [32:0] iw_reg;
    logic [15:0] e;
    logic [39:0] out_sum_reg;
    logic        out_sat_reg;
    logic        out_valid_reg;
    logic        load, exp_load, accept;
    logic [32:0] aw_sum;
    logic [48:0] self_full;
    logic [32:0] mu_sum;
    logic [48:0] contrib_full;
    logic [40:0] acc_sum;

    assign pready = 1'b1;
    assign prdata = (paddr == arp_pkg::REG_HALF_STEP) ? {16'd0, half_step_reg} : 32'd0;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_step_reg <= arp_pkg::HALF_STEP_RESET;
        else if (psel && penable && pwrite && paddr == arp_pkg::REG_HALF_STEP)
            half_step_reg <= pwdata[15:0];
    end

    assign in_ch.ready = (state_reg == arp_pkg::ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign load = accept;

    arp_lane u_lane_a (
        .clk(clk), .load(load), .img(in_ch.img_value_a), .att(in_ch.atten_value_a),
        .weight(in_ch.weight_a), .pvalid(in_ch.valid_a), .prod(prod_a)
    );
    arp_lane u_lane_b (
        .clk(clk), .load(load), .img(in_ch.img_value_b), .att(in_ch.atten_value_b),
        .weight(in_ch.weight_b), .pvalid(in_ch.valid_b), .prod(prod_b)
    );

    // Merge lanes and scale by half step
    assign aw_sum = {1'b0, prod_a.aw} + {1'b0, prod_b.aw};
    assign self_full = (49'(aw_sum) * 49'(half_step_reg) + 49'(1 << 27)) >> 28;

    // First mu step takes the fresh self term, the second the held one
    assign self_add = (state_reg == arp_pkg::ST_MU1) ? self_full[20:0] : self_reg;
    assign mu_sum = {1'b0, mu_reg} + {12'd0, self_add};

    assign exp_load = (state_reg == arp_pkg::ST_EXP);
    arp_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp (
        .clk(clk), .load(exp_load), .mu(mu_reg), .e(e)
    );

    assign contrib_full = (49'(iw_reg) * 49'(e) + 49'(1 << 14)) >> 15;
    assign acc_sum = {1'b0, sum_reg} + {7'd0, contrib_full[33:0]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arp_pkg::ST_IDLE: if (accept) state_next = arp_pkg::ST_MU1;
            arp_pkg::ST_MU1:  state_next = arp_pkg::ST_EXP;
            arp_pkg::ST_EXP:  state_next = arp_pkg::ST_ACC;
            arp_pkg::ST_ACC:  state_next = last_reg ? arp_pkg::ST_OUT : arp_pkg::ST_IDLE;
            arp_pkg::ST_OUT:  if (!out_valid_reg || out_ch.ready) state_next = arp_pkg::ST_IDLE;
            default:          state_next = arp_pkg::ST_IDLE;
        endcase
    end

    // Accumulator updates
    always_comb
    begin
        mu_next = mu_reg;
        sum_next = sum_reg;
        clip_next = clip_reg;
        unique case (state_reg)
            arp_pkg::ST_MU1:
                mu_next = mu_sum[32] ? arp_pkg::MU_MAX : mu_sum[31:0];
            arp_pkg::ST_ACC:
            begin
                mu_next = mu_sum[32] ? arp_pkg::MU_MAX : mu_sum[31:0];
                if (acc_sum[40])
                begin
                    sum_next = arp_pkg::SUM_MAX;
                    clip_next = 1'b1;
                end
                else
                    sum_next = acc_sum[39:0];
            end
            arp_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    mu_next = 32'd0;
                    sum_next = 40'd0;
                    clip_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arp_pkg::ST_IDLE;
            mu_reg <= 32'd0;
            sum_reg <= 40'd0;
            clip_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mu_reg <= mu_next;
            sum_reg <= sum_next;
            clip_reg <= clip_next;
            if (accept)
                last_reg <= in_ch.last_sample;
            if (state_reg == arp_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == arp_pkg::ST_MU1)
        begin
            self_reg <= self_full[20:0];
        end
        if (state_reg == arp_pkg::ST_MU1)
            iw_reg <= {1'b0, prod_a.iw} + {1'b0, prod_b.iw};
        if (state_reg == arp_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_sum_reg <= sum_reg;
            out_sat_reg <= clip_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.line_integral = out_sum_reg;
    assign out_ch.saturated = out_sat_reg;

    // Input taken only between samples
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == arp_pkg::ST_MU1) else $error("sample sequence broken");
    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arp_pkg::ST_OUT && state_next == arp_pkg::ST_IDLE)
        |=> (mu_reg == 32'd0 && sum_reg == 40'd0 && !clip_reg))
        else $error("accumulators not cleared");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== dv/arp_tb_pkg.sv =====
// Scoreboard class holding the ray-sum predictor and the queue of expected ray results
package arp_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [39:0] line_integral;
        logic        saturated;
    } ray_result_t;

    class ray_scoreboard;
        logic [15:0] exp_lut [256];
        logic [31:0] mu;
        logic [39:0] ray_sum;
        logic        clip;
        logic [15:0] half_step;
        ray_result_t pending [$];
        int          errors;
        int          rays_checked;
        int          clipped_rays;

        function new();
            logic [63:0] x, term, r, cur;
            x = (64'd1 << 34) / 64'd256;
            term = 64'd1 << 30;
            r = term;
            cur = 64'd1 << 30;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x) >> 30) / 64'(n);
                if (n % 2 == 1)
                    r = r - term;
                else
                    r = r + term;
            end
            for (int k = 0; k < 256; k++)
            begin
                exp_lut[k] = 16'((cur + (64'd1 << 14)) >> 15);
                cur = (cur * r + (64'd1 << 29)) >> 30;
            end
            mu = 0;
            ray_sum = 0;
            clip = 0;
            half_step = 16'd32768;
            errors = 0;
            rays_checked = 0;
            clipped_rays = 0;
        endfunction

        function logic [31:0] mu_sat_add(logic [31:0] m, logic [63:0] d);
            logic [63:0] s;
            s = 64'(m) + d;
            return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [63:0] exp_neg(logic [31:0] m);
            logic [63:0] pos, idx, f, t0, t1;
            pos = (64'(m) * 64'd256) >> 4;
            idx = pos >> 16;
            f = pos & 64'hFFFF;
            if (idx >= 256)
                return 0;
            t0 = exp_lut[idx];
            t1 = (idx + 1 < 256) ? exp_lut[idx + 1] : 0;
            if (t1 > t0)
                t1 = t0;
            return t0 - (((t0 - t1) * f + (64'd1 << 15)) >> 16);
        endfunction

        // Advance the ray state by one sample; queue the ray sum on the last one
        function void note_sample(logic [15:0] ia, logic [15:0] aa, logic [15:0] wa, logic va,
                                  logic [15:0] ib, logic [15:0] ab, logic [15:0] wb, logic vb,
                                  logic last);
            logic [63:0] aw, iw, self_att, contrib, s;
            ray_result_t res;
            aw = 0;
            iw = 0;
            if (va)
            begin
                aw += 64'(aa) * 64'(wa);
                iw += 64'(ia) * 64'(wa);
            end
            if (vb)
            begin
                aw += 64'(ab) * 64'(wb);
                iw += 64'(ib) * 64'(wb);
            end
            self_att = (aw * 64'(half_step) + (64'd1 << 27)) >> 28;
            mu = mu_sat_add(mu, self_att);
            contrib = (iw * exp_neg(mu) + (64'd1 << 14)) >> 15;
            s = 64'(ray_sum) + contrib;
            if (s > 64'hFF_FFFF_FFFF)
            begin
                s = 64'hFF_FFFF_FFFF;
                clip = 1;
            end
            ray_sum = s[39:0];
            mu = mu_sat_add(mu, self_att);
            if (last)
            begin
                res.line_integral = ray_sum;
                res.saturated = clip;
                pending.push_back(res);
                ray_sum = 0;
                mu = 0;
                clip = 0;
            end
        endfunction

        // Compare one delivered ray sum with the oldest expectation
        function void check_ray(logic [39:0] li, logic sat);
            ray_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: line_integral=%0d saturated=%0d", li, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            rays_checked++;
            if (sat)
                clipped_rays++;
            if (li !== e.line_integral)
            begin
                $error("line_integral: expected %0d, actual %0d", e.line_integral, li);
                errors++;
            end
            if (sat !== e.saturated)
            begin
                $error("saturated: expected %0d, actual %0d", e.saturated, sat);
                errors++;
            end
        endfunction
    endclass
endpackage

// ===== dv/tb_attenuated_ray_projector_unit.sv =====
// Testbench top: drives ray samples and half_step writes, checks ray sums
module tb_attenuated_ray_projector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [arp_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    arp_in_if in_ch();
    arp_out_if out_ch();

    attenuated_ray_projector_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    arp_tb_pkg::ray_scoreboard sb;
    bit quiet_mode = 0;
    int idle_cycles = 0;
    int samples_sent = 0;

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.img_value_a = 0;
        in_ch.atten_value_a = 0;
        in_ch.weight_a = 0;
        in_ch.valid_a = 0;
        in_ch.img_value_b = 0;
        in_ch.atten_value_b = 0;
        in_ch.weight_b = 0;
        in_ch.valid_b = 0;
        in_ch.last_sample = 0;
        out_ch.ready = 0;
    end

    // Check each result transfer; stall the receiver in random bursts
    always @(posedge clk)
    begin
        int gap;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_ray(out_ch.line_integral, out_ch.saturated);
            if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 9);
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk)
                    if (out_ch.valid && out_ch.ready)
                        sb.check_ray(out_ch.line_integral, out_ch.saturated);
            end
            out_ch.ready <= 1;
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_half_step(input logic [15:0] value);
        @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= arp_pkg::REG_HALF_STEP;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.half_step = value;
    endtask

    // Hold the sender until every ray sum is back and the block has settled
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] ia, aa, wa, input logic va,
                               input logic [15:0] ib, ab, wb, input logic vb,
                               input logic last);
        int gap;
        if (!quiet_mode && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.img_value_a <= ia;
        in_ch.atten_value_a <= aa;
        in_ch.weight_a <= wa;
        in_ch.valid_a <= va;
        in_ch.img_value_b <= ib;
        in_ch.atten_value_b <= ab;
        in_ch.weight_b <= wb;
        in_ch.valid_b <= vb;
        in_ch.last_sample <= last;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        sb.note_sample(ia, aa, wa, va, ib, ab, wb, vb, last);
        samples_sent++;
        in_ch.valid <= 0;
        // Let the drop of valid land before the next sample drives it; the block
        // is busy for this cycle anyway
        @(posedge clk);
    endtask

    task automatic send_random(input int mode, input logic last);
        logic [15:0] ia, aa, wa, ib, ab, wb;
        ia = 16'($urandom);
        ib = 16'($urandom);
        wa = 16'($urandom);
        wb = 16'($urandom);
        case (mode)
            0: begin aa = 16'($urandom_range(0, 255)); ab = 16'($urandom_range(0, 255)); end
            1: begin aa = 16'($urandom_range(0, 4095)); ab = 16'($urandom_range(0, 4095)); end
            default: begin aa = 16'($urandom); ab = 16'($urandom); end
        endcase
        send_sample(ia, aa, wa, $urandom_range(0, 9) != 0, ib, ab, wb,
                    $urandom_range(0, 9) != 0, last);
    endtask

    task automatic random_rays(input int count);
        int n, len, mode;
        n = 0;
        while (n < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                send_random(mode, i == len - 1);
            n += len;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: zero, extremes, invalid points, large attenuation, overflow
        send_sample(0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_sample(16'hFFFF, 0, 16'hFFFF, 1, 16'hFFFF, 0, 16'hFFFF, 1, 1);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1);
        send_sample(1000, 16'h1000, 16'h8000, 1, 2000, 16'h0800, 16'h8000, 1, 0);
        send_sample(1000, 16'h1000, 16'h8000, 1, 2000, 16'h0800, 16'h8000, 1, 0);
        send_sample(16'hAAAA, 16'h5555, 16'h5555, 1, 16'h5555, 16'hAAAA, 16'hAAAA, 1, 1);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
        drain();

        // Zero half_step: no attenuation, long ray of bright samples stays below the sum's clip limit
        write_half_step(16'd0);
        for (int i = 0; i < 16; i++)
            send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
        send_sample(16'hFFFF, 0, 16'hFFFF, 1, 16'hFFFF, 0, 16'hFFFF, 1, 1);
        random_rays(100);
        drain();

        write_half_step(16'hFFFF);
        random_rays(120);
        drain();

        write_half_step(16'd1);
        random_rays(100);
        drain();

        write_half_step(16'($urandom));
        random_rays(120);
        drain();

        // Last part: no idling on either side
        write_half_step(arp_pkg::HALF_STEP_RESET);
        quiet_mode = 1;
        random_rays(140);
        drain();

        $display("Sent %0d samples, checked %0d ray sums (%0d clipped) over 6 half_step settings.",
                 samples_sent, sb.rays_checked, sb.clipped_rays);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/arp_pkg.sv
rtl/arp_if.sv
rtl/arp_lane.sv
rtl/arp_exp.sv
rtl/attenuated_ray_projector_unit.sv
dv/arp_tb_pkg.sv
dv/tb_attenuated_ray_projector_unit.sv
